// ----- rtl/biquad_lowpass_filter_bank_core_defines.svh -----
// Assertion macros used by the filter bank top level.
`ifndef BIQUAD_LOWPASS_FILTER_BANK_CORE_DEFINES_SVH
`define BIQUAD_LOWPASS_FILTER_BANK_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define BLFB_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define BLFB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/blfb_pkg.sv -----
// Package with the types, constants and codes of the low-pass filter bank.
`timescale 1ns / 1ps
package blfb_pkg;

  localparam int CHANNELS_DEF       = 16;
  localparam int COEF_FRAC_BITS_DEF = 30;

  localparam int CHAN_BITS   = 4;
  localparam int DBSEL_BITS  = 2;
  localparam int SAMPLE_BITS = 16;
  localparam int YSTATE_BITS = 24;
  localparam int COEF_BITS   = 32;
  localparam int DB_BITS     = 15;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  // Wide enough for b0*(x + 2*x1 + x2)*256 - a1*y1 - a2*y2 plus rounding.
  localparam int ACC_W       = 60;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SET0_B0    = 3'd0,
    REG_SET0_A1    = 3'd1,
    REG_SET0_A2    = 3'd2,
    REG_SET1_B0    = 3'd3,
    REG_SET1_A1    = 3'd4,
    REG_SET1_A2    = 3'd5,
    REG_DEADBAND_A = 3'd6,
    REG_DEADBAND_B = 3'd7
  } blfb_reg_e;

  typedef enum logic [DBSEL_BITS-1:0] {
    DB_NONE = 2'd0,
    DB_A    = 2'd1,
    DB_B    = 2'd2
  } blfb_dbsel_e;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] set0_b0;
    logic signed [COEF_BITS-1:0] set0_a1;
    logic signed [COEF_BITS-1:0] set0_a2;
    logic signed [COEF_BITS-1:0] set1_b0;
    logic signed [COEF_BITS-1:0] set1_a1;
    logic signed [COEF_BITS-1:0] set1_a2;
    logic        [DB_BITS-1:0]   deadband_a;
    logic        [DB_BITS-1:0]   deadband_b;
  } blfb_cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] x1;
    logic signed [SAMPLE_BITS-1:0] x2;
    logic signed [YSTATE_BITS-1:0] y1;
    logic signed [YSTATE_BITS-1:0] y2;
  } blfb_state_t;

endpackage

// ----- rtl/blfb_if.sv -----
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps
interface blfb_in_if;
  logic                                       valid;
  logic                                       ready;
  logic        [blfb_pkg::CHAN_BITS-1:0]      channel;
  logic                                       coeff_set;
  logic        [blfb_pkg::DBSEL_BITS-1:0]     deadband_sel;
  logic signed [blfb_pkg::SAMPLE_BITS-1:0]    sample;

  modport source (output valid, channel, coeff_set, deadband_sel, sample, input ready);
  modport sink   (input valid, channel, coeff_set, deadband_sel, sample, output ready);
endinterface

interface blfb_out_if;
  logic                                       valid;
  logic                                       ready;
  logic        [blfb_pkg::CHAN_BITS-1:0]      out_channel;
  logic signed [blfb_pkg::SAMPLE_BITS-1:0]    filtered;
  logic                                       saturated;

  modport source (output valid, out_channel, filtered, saturated, input ready);
  modport sink   (input valid, out_channel, filtered, saturated, output ready);
endinterface

// ----- rtl/blfb_cfg.sv -----
// Coefficient and deadband register file written through the config port.
`timescale 1ns / 1ps
module blfb_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [blfb_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [blfb_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output blfb_pkg::blfb_cfg_t                 cfg_o
);

  blfb_pkg::blfb_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        blfb_pkg::REG_SET0_B0:    cfg_d.set0_b0    = cfg_data_i;
        blfb_pkg::REG_SET0_A1:    cfg_d.set0_a1    = cfg_data_i;
        blfb_pkg::REG_SET0_A2:    cfg_d.set0_a2    = cfg_data_i;
        blfb_pkg::REG_SET1_B0:    cfg_d.set1_b0    = cfg_data_i;
        blfb_pkg::REG_SET1_A1:    cfg_d.set1_a1    = cfg_data_i;
        blfb_pkg::REG_SET1_A2:    cfg_d.set1_a2    = cfg_data_i;
        blfb_pkg::REG_DEADBAND_A: cfg_d.deadband_a = cfg_data_i[blfb_pkg::DB_BITS-1:0];
        blfb_pkg::REG_DEADBAND_B: cfg_d.deadband_b = cfg_data_i[blfb_pkg::DB_BITS-1:0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/blfb_state_mem.sv -----
// Per-channel delay state memory with valid bits and same-channel forwarding.
`timescale 1ns / 1ps
module blfb_state_mem #(
  parameter int CHANNELS = blfb_pkg::CHANNELS_DEF,
  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    rd_en_i,
  input  logic                    rd_ok_i,
  input  logic [CH_W-1:0]         rd_idx_i,
  input  logic                    fwd_i,
  input  logic                    wr_en_i,
  input  logic [CH_W-1:0]         wr_idx_i,
  input  blfb_pkg::blfb_state_t   wr_state_i,
  output blfb_pkg::blfb_state_t   rd_state_o
);

  blfb_pkg::blfb_state_t mem [CHANNELS];
  logic [CHANNELS-1:0]   vld_q;
  blfb_pkg::blfb_state_t rd_data_q;
  blfb_pkg::blfb_state_t fwd_data_q;
  logic                  fwd_q;
  logic                  zero_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_state_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i && fwd_i) begin
      fwd_data_q <= wr_state_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_idx_i] <= 1'b1;
    end
  end

  // An entry never written since reset, or a channel outside the bank,
  // reads as all-zero delay state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q  <= 1'b0;
      zero_q <= 1'b1;
    end else if (rd_en_i) begin
      fwd_q  <= fwd_i;
      zero_q <= !rd_ok_i || !vld_q[rd_idx_i];
    end
  end

  always_comb begin
    if (fwd_q) begin
      rd_state_o = fwd_data_q;
    end else if (zero_q) begin
      rd_state_o = '0;
    end else begin
      rd_state_o = rd_data_q;
    end
  end

endmodule

// ----- rtl/blfb_calc.sv -----
// Biquad arithmetic: products, rounding, saturation, deadband, next state.
`timescale 1ns / 1ps
module blfb_calc #(
  parameter int COEF_FRAC_BITS = blfb_pkg::COEF_FRAC_BITS_DEF
) (
  input  blfb_pkg::blfb_cfg_t                    cfg_i,
  input  blfb_pkg::blfb_state_t                  state_i,
  input  logic                                   coeff_set_i,
  input  logic        [blfb_pkg::DBSEL_BITS-1:0] deadband_sel_i,
  input  logic signed [blfb_pkg::SAMPLE_BITS-1:0] sample_i,
  output logic signed [blfb_pkg::SAMPLE_BITS-1:0] filtered_o,
  output logic                                   saturated_o,
  output blfb_pkg::blfb_state_t                  state_o
);

  localparam int AW = blfb_pkg::ACC_W;

  logic signed [31:0]   b0, a1, a2;
  logic signed [18:0]   xsum;
  logic signed [50:0]   p0;
  logic signed [55:0]   p1, p2;
  logic signed [AW-1:0] acc, v, r;
  logic signed [15:0]   r16;
  logic signed [23:0]   ys24;
  logic                 sat_r, sat_y;
  logic signed [16:0]   r17, mag;
  logic [blfb_pkg::DB_BITS-1:0] thr;
  logic                 use_db;

  assign b0 = coeff_set_i ? cfg_i.set1_b0 : cfg_i.set0_b0;
  assign a1 = coeff_set_i ? cfg_i.set1_a1 : cfg_i.set0_a1;
  assign a2 = coeff_set_i ? cfg_i.set1_a2 : cfg_i.set0_a2;

  // b1 = 2*b0 and b2 = b0, so the feed-forward part needs one product.
  assign xsum = 19'(sample_i) + (19'(state_i.x1) <<< 1) + 19'(state_i.x2);
  assign p0   = 51'(b0) * 51'(xsum);
  assign p1   = 56'(a1) * 56'(state_i.y1);
  assign p2   = 56'(a2) * 56'(state_i.y2);

  assign acc = (AW'(p0) <<< 8) - AW'(p1) - AW'(p2)
             + (AW'(1) <<< (COEF_FRAC_BITS - 1));
  assign v   = acc >>> COEF_FRAC_BITS;
  assign r   = (v + AW'(128)) >>> 8;

  always_comb begin
    sat_r = 1'b0;
    r16   = 16'(r);
    if (r > AW'(32767)) begin
      r16   = 16'sh7fff;
      sat_r = 1'b1;
    end else if (r < -AW'(32768)) begin
      r16   = -16'sh8000;
      sat_r = 1'b1;
    end
  end

  always_comb begin
    sat_y = 1'b0;
    ys24  = 24'(v);
    if (v > AW'(8388607)) begin
      ys24  = 24'sh7fffff;
      sat_y = 1'b1;
    end else if (v < -AW'(8388608)) begin
      ys24  = -24'sh800000;
      sat_y = 1'b1;
    end
  end

  always_comb begin
    case (blfb_pkg::blfb_dbsel_e'(deadband_sel_i))
      blfb_pkg::DB_A: begin
        thr    = cfg_i.deadband_a;
        use_db = 1'b1;
      end
      blfb_pkg::DB_B: begin
        thr    = cfg_i.deadband_b;
        use_db = 1'b1;
      end
      default: begin
        thr    = '0;
        use_db = 1'b0;
      end
    endcase
  end

  assign r17 = 17'(r16);
  assign mag = r17[16] ? -r17 : r17;

  assign filtered_o  = (use_db && ($unsigned(mag) < {2'b00, thr})) ? '0 : r16;
  assign saturated_o = sat_r || sat_y;

  // The stored state keeps the value before the deadband.
  assign state_o.x1 = sample_i;
  assign state_o.x2 = state_i.x1;
  assign state_o.y1 = ys24;
  assign state_o.y2 = state_i.y1;

endmodule

// ----- rtl/biquad_lowpass_filter_bank_core.sv -----
// Top level of the multi-channel second-order low-pass filter bank.
`timescale 1ns / 1ps
//
// Each input item names a channel, one of two coefficient sets, a deadband
// choice and a signed 16-bit sample; each item yields exactly one result
// item carrying the echoed channel, the filtered sample and a flag that is
// set when the output or the stored feedback value was clipped.
// Coefficients and deadband thresholds are written through the cfg port
// (write enable, index, data); the user must do so only while no item is in
// flight, which the block does not enforce. The block takes one item per
// cycle while the receiver keeps up. An accepted item enters the input
// stage, where its channel's delay state arrives from the registered read
// of the state memory, then moves on when the output register is free.
// Back-to-back items on the same channel get the freshly computed state
// through a forwarding path around the state memory write.
// Reset clears the coefficients, thresholds and all per-channel valid bits,
// so every channel starts from zero delay state with no clearing sweep.
// When the receiver stalls, the output register holds its item; the input
// stage can still take one more item, and ready drops only when both are
// full.
//
`include "biquad_lowpass_filter_bank_core_defines.svh"
module biquad_lowpass_filter_bank_core #(
  parameter int CHANNELS       = blfb_pkg::CHANNELS_DEF,
  parameter int COEF_FRAC_BITS = blfb_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  blfb_in_if.sink                         in_i,
  blfb_out_if.source                      out_o,
  input  logic                            cfg_we_i,
  input  logic [blfb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [blfb_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [8:0] CHAN_LIMIT = 9'(CHANNELS);

  blfb_pkg::blfb_cfg_t   cfg;
  blfb_pkg::blfb_state_t rd_state;
  blfb_pkg::blfb_state_t new_state;

  logic in_acc, in_ready, s1_adv, in_ch_ok, fwd;

  logic                                     s1_valid_q;
  logic                                     s1_ch_ok_q;
  logic        [blfb_pkg::CHAN_BITS-1:0]    s1_ch_q;
  logic                                     s1_set_q;
  logic        [blfb_pkg::DBSEL_BITS-1:0]   s1_dsel_q;
  logic signed [blfb_pkg::SAMPLE_BITS-1:0]  s1_sample_q;

  logic signed [blfb_pkg::SAMPLE_BITS-1:0]  filtered;
  logic                                     saturated;

  logic                                     out_valid_q;
  logic        [blfb_pkg::CHAN_BITS-1:0]    out_ch_q;
  logic signed [blfb_pkg::SAMPLE_BITS-1:0]  out_filt_q;
  logic                                     out_sat_q;

  // Handshake: the input stage moves on whenever the output register is
  // empty or being emptied in this cycle.
  assign s1_adv   = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready = !s1_valid_q || s1_adv;
  assign in_i.ready = in_ready;
  assign in_acc   = in_i.valid && in_ready;

  assign in_ch_ok = {5'b00000, in_i.channel} < CHAN_LIMIT;
  // The item leaving the input stage writes the same channel the new item
  // reads, so its result state must bypass the memory.
  assign fwd      = s1_adv && s1_ch_ok_q && (in_i.channel == s1_ch_q);

  blfb_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  blfb_state_mem #(
    .CHANNELS (CHANNELS)
  ) u_state_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_acc),
    .rd_ok_i    (in_ch_ok),
    .rd_idx_i   (CH_W'(in_i.channel)),
    .fwd_i      (fwd),
    .wr_en_i    (s1_adv && s1_ch_ok_q),
    .wr_idx_i   (CH_W'(s1_ch_q)),
    .wr_state_i (new_state),
    .rd_state_o (rd_state)
  );

  blfb_calc #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_calc (
    .cfg_i          (cfg),
    .state_i        (rd_state),
    .coeff_set_i    (s1_set_q),
    .deadband_sel_i (s1_dsel_q),
    .sample_i       (s1_sample_q),
    .filtered_o     (filtered),
    .saturated_o    (saturated),
    .state_o        (new_state)
  );

  // Input stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_ch_ok_q  <= in_ch_ok;
      s1_ch_q     <= in_i.channel;
      s1_set_q    <= in_i.coeff_set;
      s1_dsel_q   <= in_i.deadband_sel;
      s1_sample_q <= in_i.sample;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_ch_q   <= s1_ch_q;
      out_filt_q <= filtered;
      out_sat_q  <= saturated;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_channel = out_ch_q;
  assign out_o.filtered    = out_filt_q;
  assign out_o.saturated   = out_sat_q;

  `BLFB_ASSERT_SAME(a_full_blocks_input, clk_i, rst_ni,
                    s1_valid_q && out_valid_q && !out_o.ready, !in_i.ready,
                    "input accepted while both stages are full and stalled")
  `BLFB_ASSERT_NEXT(a_accept_fills_stage, clk_i, rst_ni,
                    in_acc, s1_valid_q,
                    "accepted item did not reach the input stage")
  `BLFB_ASSERT_NEXT(a_advance_moves_channel, clk_i, rst_ni,
                    s1_adv, out_valid_q && (out_ch_q == $past(s1_ch_q)),
                    "result register does not hold the advanced item")
  `BLFB_ASSERT_SAME(a_forward_needs_write, clk_i, rst_ni,
                    fwd, s1_adv && s1_ch_ok_q,
                    "state forwarded without a matching write")

endmodule
